### rtl/ffba_pkg.sv
// ffba_pkg: shared types, widths and codes of the first-fit block allocator.
// Used by the channel interfaces, the header walker and the top level.
`default_nettype none

package ffba_pkg;

  localparam int ARENA_BYTES_DEF  = 1024;
  localparam int HEADER_BYTES_DEF = 8;

  localparam int REQ_SIZE_W = 11;
  localparam int ADDR_W     = 32;
  localparam int STATUS_W   = 2;
  localparam int USED_W     = 11;
  localparam int LIVE_W     = 8;

  localparam int CFG_ARENA_W = 11;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_ARENA_W-1:0] ARENA_RESET = CFG_ARENA_W'(1024);

  localparam logic [CFG_IDX_W-1:0] CFG_ARENA_BYTES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ARENA_BASE  = 1'b1;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_GRANTED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OOM     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOFIT   = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FREED   = 2'd3;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_WALK,
    S_FREE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic                  mode;
    logic [REQ_SIZE_W-1:0] request_size;
    logic [ADDR_W-1:0]     block_address;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   payload_address;
    logic [STATUS_W-1:0] status;
    logic                free_error;
    logic [USED_W-1:0]   used_bytes;
    logic [LIVE_W-1:0]   live_blocks;
  } res_t;

endpackage

`default_nettype wire

### rtl/ffba_if.sv
// ffba_if: valid/ready channel interfaces for requests and results.
// Depends on ffba_pkg for field widths.
`default_nettype none

interface ffba_in_if;
  import ffba_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  mode;
  logic [REQ_SIZE_W-1:0] request_size;
  logic [ADDR_W-1:0]     block_address;

  modport source (output valid, mode, request_size, block_address, input ready);
  modport sink   (input valid, mode, request_size, block_address, output ready);
endinterface

interface ffba_out_if;
  import ffba_pkg::*;

  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   payload_address;
  logic [STATUS_W-1:0] status;
  logic                free_error;
  logic [USED_W-1:0]   used_bytes;
  logic [LIVE_W-1:0]   live_blocks;

  modport source (output valid, payload_address, status, free_error, used_bytes,
                  live_blocks, input ready);
  modport sink   (input valid, payload_address, status, free_error, used_bytes,
                  live_blocks, output ready);
endinterface

`default_nettype wire

### rtl/ffba_ram.sv
// ffba_ram: generic single-write, single-read synchronous RAM.
// Read data is registered. No dependencies.
`default_nettype none

module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### rtl/ffba_walker.sv
// ffba_walker: header-walk sequencer with the byte and block counters.
// Clears the header RAM after reset, then reads, tests and writes back headers.
// Depends on ffba_pkg; drives the ports of one ffba_ram.
`default_nettype none

module ffba_walker #(
  parameter int ARENA_BYTES  = ffba_pkg::ARENA_BYTES_DEF,
  parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF,
  parameter int AW           = $clog2(ARENA_BYTES)
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic [ffba_pkg::CFG_ARENA_W-1:0]   arena_bytes,
  input  wire logic [ffba_pkg::ADDR_W-1:0]        arena_base,
  input  wire logic                               req_valid,
  output logic                                    req_ready,
  input  wire ffba_pkg::req_t                     req,
  output logic                                    res_valid,
  input  wire logic                               res_ready,
  output ffba_pkg::res_t                          res,
  output logic                                    ram_we,
  output logic      [AW-1:0]                      ram_waddr,
  output logic      [AW:0]                        ram_wdata,
  output logic      [AW-1:0]                      ram_raddr,
  input  wire logic [AW:0]                        ram_rdata
);
  import ffba_pkg::*;

  localparam int EW = $clog2(ARENA_BYTES + 1);
  localparam int CW = (EW > 12 ? EW : 12) + 3;
  localparam int NW = $clog2(ARENA_BYTES / HEADER_BYTES + 1);
  localparam logic [CW-1:0]     HDR_C   = CW'(HEADER_BYTES);
  localparam logic [CW-1:0]     ARENA_C = CW'(ARENA_BYTES);
  localparam logic [AW-1:0]     CLR_END = AW'(ARENA_BYTES - 1);
  localparam logic [ADDR_W-1:0] HDR_A   = ADDR_W'(HEADER_BYTES);

  state_t state_r, state_nxt;

  logic [AW-1:0]         clr_r, clr_nxt;
  logic [AW-1:0]         pos_r, pos_nxt;
  logic [EW-1:0]         alloc_r, alloc_nxt;
  logic [NW-1:0]         count_r, count_nxt;
  logic                  mode_r, mode_nxt;
  logic [REQ_SIZE_W-1:0] size_r, size_nxt;
  logic [ADDR_W-1:0]     baddr_r, baddr_nxt;
  logic [ADDR_W-1:0]     addr_r, addr_nxt;
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic                  ferr_r, ferr_nxt;

  logic [CW-1:0]     arena_c, eff_c, need_c, used_c, npos_c, sz_c, pay_c, alloc_c;
  logic [ADDR_W-1:0] off_c;
  logic              oom, fit0, off_bad;
  logic [AW-1:0]     rd_size;
  logic              rd_use, take_new, take_reuse, dead, npos_fit, free_ok;

  assign arena_c  = CW'(arena_bytes);
  assign eff_c    = (arena_c > ARENA_C) ? ARENA_C : arena_c;
  assign need_c   = CW'(size_r) + HDR_C;
  assign alloc_c  = CW'(alloc_r);
  assign used_c   = need_c + alloc_c + CW'(count_r) * HDR_C;
  assign oom      = used_c > eff_c;
  assign fit0     = eff_c > need_c;
  assign off_c    = baddr_r - arena_base - HDR_A;
  assign off_bad  = off_c >= ADDR_W'(eff_c);

  assign rd_size    = ram_rdata[AW-1:0];
  assign rd_use     = ram_rdata[AW];
  assign sz_c       = CW'(rd_size);
  assign npos_c     = CW'(pos_r) + sz_c;
  assign npos_fit   = eff_c > (npos_c + need_c);
  assign take_new   = !rd_use && (rd_size == '0);
  assign take_reuse = !rd_use && (sz_c > need_c);
  assign dead       = rd_use && (rd_size == '0);
  assign free_ok    = rd_use && (rd_size != '0);
  assign pay_c      = sz_c - HDR_C;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_r == CLR_END) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) state_nxt = S_START;
      end
      S_START: begin
        if (mode_r == MODE_FREE) begin
          state_nxt = off_bad ? S_RESP : S_FREE;
        end else begin
          state_nxt = (oom || !fit0) ? S_RESP : S_WALK;
        end
      end
      S_WALK: begin
        if (take_new || take_reuse || dead || !npos_fit) state_nxt = S_RESP;
      end
      S_FREE: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    clr_nxt    = clr_r;
    pos_nxt    = pos_r;
    alloc_nxt  = alloc_r;
    count_nxt  = count_r;
    mode_nxt   = mode_r;
    size_nxt   = size_r;
    baddr_nxt  = baddr_r;
    addr_nxt   = addr_r;
    status_nxt = status_r;
    ferr_nxt   = ferr_r;
    ram_we     = 1'b0;
    ram_waddr  = pos_r;
    ram_wdata  = '0;
    ram_raddr  = pos_r;
    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + AW'(1);
      end
      S_IDLE: begin
        if (req_valid) begin
          mode_nxt  = req.mode;
          size_nxt  = req.request_size;
          baddr_nxt = req.block_address;
        end
      end
      S_START: begin
        addr_nxt = '0;
        if (mode_r == MODE_FREE) begin
          ram_raddr  = off_c[AW-1:0];
          pos_nxt    = off_c[AW-1:0];
          status_nxt = STATUS_FREED;
          ferr_nxt   = 1'b1;
        end else begin
          ram_raddr  = '0;
          pos_nxt    = '0;
          status_nxt = oom ? STATUS_OOM : STATUS_NOFIT;
          ferr_nxt   = 1'b0;
        end
      end
      S_WALK: begin
        if (take_new || take_reuse) begin
          ram_we     = 1'b1;
          ram_wdata  = {1'b1, take_new ? need_c[AW-1:0] : rd_size};
          alloc_nxt  = EW'(alloc_c + (take_new ? CW'(size_r) : pay_c));
          count_nxt  = count_r + NW'(1);
          status_nxt = STATUS_GRANTED;
          addr_nxt   = arena_base + ADDR_W'(pos_r) + HDR_A;
        end else if (!dead && npos_fit) begin
          pos_nxt   = npos_c[AW-1:0];
          ram_raddr = npos_c[AW-1:0];
        end
      end
      S_FREE: begin
        if (free_ok) begin
          ram_we    = 1'b1;
          ram_wdata = {1'b0, rd_size};
          alloc_nxt = (alloc_c > pay_c) ? EW'(alloc_c - pay_c) : '0;
          count_nxt = (count_r != '0) ? count_r - NW'(1) : '0;
          ferr_nxt  = 1'b0;
        end
      end
      S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      alloc_r <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      alloc_r <= alloc_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    mode_r   <= mode_nxt;
    size_r   <= size_nxt;
    baddr_r  <= baddr_nxt;
    addr_r   <= addr_nxt;
    status_r <= status_nxt;
    ferr_r   <= ferr_nxt;
  end

  logic [CW-1:0] used_ext, live_ext;
  assign used_ext = CW'(alloc_r);
  assign live_ext = CW'(count_r);

  assign req_ready           = (state_r == S_IDLE);
  assign res_valid           = (state_r == S_RESP);
  assign res.payload_address = addr_r;
  assign res.status          = status_r;
  assign res.free_error      = ferr_r;
  assign res.used_bytes      = used_ext[USED_W-1:0];
  assign res.live_blocks     = live_ext[LIVE_W-1:0];

endmodule

`default_nettype wire

### rtl/first_fit_block_allocator_core.sv
// first_fit_block_allocator_core: first-fit allocator over a byte arena whose
// block headers live in one RAM of ARENA_BYTES entries. Depends on ffba_pkg,
// ffba_if, ffba_ram and ffba_walker.
//
// One request is handled at a time. After reset the header RAM is cleared one
// entry per cycle; no request is accepted during that pass, configuration
// writes are. A free request passes the start state, then the free state unless
// its address is outside the arena. An allocate request passes the start state,
// then, if it can fit, walks headers from offset 0, one RAM read per cycle;
// at most ARENA_BYTES / HEADER_BYTES headers (128 by default). The result sits
// in an output register, so a new request is accepted while it waits.
`default_nettype none

module first_fit_block_allocator_core #(
  parameter int ARENA_BYTES  = ffba_pkg::ARENA_BYTES_DEF,
  parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [ffba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ffba_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  ffba_in_if.sink                               in_ch,
  ffba_out_if.source                            out_ch
);
  import ffba_pkg::*;

  localparam int AW = $clog2(ARENA_BYTES);

  logic [CFG_ARENA_W-1:0] arena_bytes_r;
  logic [ADDR_W-1:0]      arena_base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arena_bytes_r <= ARENA_RESET;
      arena_base_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ARENA_BYTES: arena_bytes_r <= cfg_wdata[CFG_ARENA_W-1:0];
        CFG_ARENA_BASE:  arena_base_r  <= cfg_wdata[ADDR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  req_t          req;
  res_t          res;
  logic          res_valid, res_ready;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [AW:0]   ram_wdata, ram_rdata;

  assign req.mode          = in_ch.mode;
  assign req.request_size  = in_ch.request_size;
  assign req.block_address = in_ch.block_address;

  ffba_walker #(
    .ARENA_BYTES  (ARENA_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .AW           (AW)
  ) u_walker (
    .clk         (clk),
    .rst_n       (rst_n),
    .arena_bytes (arena_bytes_r),
    .arena_base  (arena_base_r),
    .req_valid   (in_ch.valid),
    .req_ready   (in_ch.ready),
    .req         (req),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata)
  );

  ffba_ram #(
    .WIDTH (AW + 1),
    .DEPTH (ARENA_BYTES)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic out_valid_r;
  res_t out_res_r;

  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.payload_address = out_res_r.payload_address;
  assign out_ch.status          = out_res_r.status;
  assign out_ch.free_error      = out_res_r.free_error;
  assign out_ch.used_bytes      = out_res_r.used_bytes;
  assign out_ch.live_blocks     = out_res_r.live_blocks;

endmodule

`default_nettype wire

### tb/tb_first_fit_block_allocator_core.sv
// Self-checking testbench for first_fit_block_allocator_core: drives allocate and free requests,
// predicts every result from a model of the header walk and compares field by field.
// Depends on ffba_pkg, ffba_in_if and ffba_out_if from the RTL.
`timescale 1ns / 100ps

module tb_first_fit_block_allocator_core;
  import ffba_pkg::*;

  localparam int ARENA = ARENA_BYTES_DEF;
  localparam int HDR   = HEADER_BYTES_DEF;

  class allocator_scoreboard;
    bit [10:0]   block_size [ARENA];
    bit          block_busy [ARENA];
    int unsigned payload_total;
    int unsigned live_total;
    bit [10:0]   arena_reg;
    bit [31:0]   base_reg;
    res_t        awaited_results[$];
    int unsigned live_offsets[$];
    int unsigned freed_offsets[$];
    int unsigned mismatches, requests, grants, reuses, ooms, nofits, frees, bad_frees;

    function new();
      foreach (block_size[i]) begin
        block_size[i] = '0;
        block_busy[i] = 1'b0;
      end
      payload_total = 0;
      live_total    = 0;
      arena_reg     = ARENA_RESET;
      base_reg      = '0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] index, logic [31:0] value);
      if (index == CFG_ARENA_BYTES) arena_reg = value[10:0];
      else base_reg = value;
    endfunction

    function int unsigned span();
      return (arena_reg > ARENA) ? ARENA : arena_reg;
    endfunction

    function res_t predict_alloc(int unsigned req);
      res_t r;
      int   arena, need, room, pos, sz;
      bit   placed;
      r      = '0;
      arena  = int'(span());
      need   = int'(req) + HDR;
      room   = arena - (int'(payload_total) + int'(live_total) * HDR);
      pos    = 0;
      placed = 1'b0;
      if (need > room) begin
        r.status = STATUS_OOM;
        ooms++;
      end else begin
        while (arena > pos + need) begin
          sz = int'(block_size[pos]);
          if (!block_busy[pos] && sz == 0) begin
            block_size[pos] = need[10:0];
            payload_total  += req;
            placed = 1'b1;
            break;
          end else if (!block_busy[pos] && sz > need) begin
            payload_total += sz - HDR;
            placed = 1'b1;
            reuses++;
            break;
          end else if (sz == 0) begin
            break;
          end
          pos += sz;
        end
        if (placed) begin
          block_busy[pos] = 1'b1;
          live_total++;
          live_offsets.push_back(pos);
          r.payload_address = base_reg + 32'(pos) + 32'(HDR);
          r.status = STATUS_GRANTED;
          grants++;
        end else begin
          r.status = STATUS_NOFIT;
          nofits++;
        end
      end
      r.used_bytes  = payload_total[USED_W-1:0];
      r.live_blocks = live_total[LIVE_W-1:0];
      return r;
    endfunction

    function res_t predict_release(logic [31:0] addr);
      res_t        r;
      logic [31:0] off;
      int unsigned pay;
      r        = '0;
      r.status = STATUS_FREED;
      off      = addr - base_reg - 32'(HDR);
      frees++;
      if (off >= span() || block_size[off] == 0 || !block_busy[off]) begin
        r.free_error = 1'b1;
        bad_frees++;
      end else begin
        block_busy[off] = 1'b0;
        pay = block_size[off] - HDR;
        payload_total = (payload_total > pay) ? payload_total - pay : 0;
        if (live_total > 0) live_total--;
        foreach (live_offsets[i])
          if (live_offsets[i] == off) begin
            live_offsets.delete(i);
            break;
          end
        freed_offsets.push_back(off);
        if (freed_offsets.size() > 8) void'(freed_offsets.pop_front());
      end
      r.used_bytes  = payload_total[USED_W-1:0];
      r.live_blocks = live_total[LIVE_W-1:0];
      return r;
    endfunction

    function void note_request(logic mode, logic [10:0] size, logic [31:0] addr);
      requests++;
      if (mode == MODE_ALLOC) awaited_results.push_back(predict_alloc(size));
      else awaited_results.push_back(predict_release(addr));
    endfunction

    function void flag_error(string what);
      mismatches++;
      if (mismatches <= 10) $display("ERROR at %0t: %s", $realtime, what);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (awaited_results.size() == 0) begin
        flag_error($sformatf("result with nothing pending: addr %h status %0d",
                             got.payload_address, got.status));
        return;
      end
      want = awaited_results.pop_front();
      if (got.payload_address !== want.payload_address || got.status !== want.status ||
          got.free_error !== want.free_error || got.used_bytes !== want.used_bytes ||
          got.live_blocks !== want.live_blocks)
        flag_error($sformatf({"expected addr %h status %0d err %0b used %0d live %0d, ",
                              "got addr %h status %0d err %0b used %0d live %0d"},
                             want.payload_address, want.status, want.free_error,
                             want.used_bytes, want.live_blocks, got.payload_address,
                             got.status, got.free_error, got.used_bytes, got.live_blocks));
    endfunction

    function int outstanding();
      return awaited_results.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    burst_left;
  int unsigned           hold_count;

  allocator_scoreboard sb = new();

  ffba_in_if  in_ch ();
  ffba_out_if out_ch ();

  first_fit_block_allocator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #5 clk = ~clk;

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic offer(input logic mode, input logic [10:0] size, input logic [31:0] addr);
    if (burst_left <= 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 24);
    end
    in_ch.valid         <= 1'b1;
    in_ch.mode          <= mode;
    in_ch.request_size  <= size;
    in_ch.block_address <= addr;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(mode, size, addr);
    burst_left--;
  endtask

  task automatic allocate(input logic [10:0] size);
    offer(MODE_ALLOC, size, $urandom);
  endtask

  task automatic release_at(input logic [31:0] addr);
    offer(MODE_FREE, 11'($urandom_range(0, 1024)), addr);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic program_arena(input logic [10:0] bytes, input logic [31:0] base);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ARENA_BYTES;
    cfg_wdata <= 32'(bytes);
    @(posedge clk);
    sb.set_register(CFG_ARENA_BYTES, 32'(bytes));
    cfg_index <= CFG_ARENA_BASE;
    cfg_wdata <= base;
    @(posedge clk);
    sb.set_register(CFG_ARENA_BASE, base);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic churn(input int count);
    int unsigned span, off;
    int          roll;
    repeat (count) begin
      span = sb.span();
      roll = $urandom_range(0, 99);
      if (sb.live_offsets.size() == 0 || $urandom_range(0, 99) < 55) begin
        if (roll < 70) allocate(11'($urandom_range(0, span / 16)));
        else if (roll < 92) allocate(11'($urandom_range(0, span / 4)));
        else allocate(11'($urandom_range(0, 1024)));
      end else if (roll < 80) begin
        off = sb.live_offsets[$urandom_range(0, sb.live_offsets.size() - 1)];
        release_at(sb.base_reg + off + HDR);
      end else if (roll < 88 && sb.freed_offsets.size() != 0) begin
        off = sb.freed_offsets[$urandom_range(0, sb.freed_offsets.size() - 1)];
        release_at(sb.base_reg + off + HDR);
      end else if (roll < 94) begin
        off = sb.live_offsets[$urandom_range(0, sb.live_offsets.size() - 1)];
        release_at(sb.base_reg + off + HDR + $urandom_range(1, 7));
      end else begin
        release_at($urandom);
      end
    end
  endtask

  initial begin : result_sink
    res_t        got;
    int unsigned cycle_no, hold_left, style_left;
    int          style;
    cycle_no   = 0;
    hold_left  = 0;
    style_left = 0;
    style      = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.payload_address = out_ch.payload_address;
        got.status          = out_ch.status;
        got.free_error      = out_ch.free_error;
        got.used_bytes      = out_ch.used_bytes;
        got.live_blocks     = out_ch.live_blocks;
        sb.check_result(got);
      end
      if (cycle_no % 40000 == 3000) begin
        hold_left = 300 + $urandom_range(0, 100);
        hold_count++;
      end
      cycle_no++;
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        if (style_left == 0) begin
          style      = $urandom_range(0, 2);
          style_left = $urandom_range(20, 200);
        end
        style_left--;
        case (style)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    logic [10:0] phase_arena [7];
    int          phase_items [7];
    logic [31:0] base;
    phase_arena = '{11'd1024, 11'd2047, 11'd16, 11'd200, 11'd64, 11'd1024, 11'd512};
    phase_items = '{300, 250, 100, 200, 150, 250, 150};
    clk                 = 1'b0;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = CFG_ARENA_BYTES;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.mode          = MODE_ALLOC;
    in_ch.request_size  = '0;
    in_ch.block_address = '0;
    out_ch.ready        = 1'b0;
    burst_left          = 0;
    hold_count          = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    allocate(11'd1024);
    allocate(11'd1016);
    allocate(11'd0);
    allocate(11'd100);
    allocate(11'd40);
    release_at(32'd16);
    release_at(32'd16);
    allocate(11'd50);
    release_at(32'd17);
    release_at(32'd0);
    release_at(32'hFFFF_FFFF);
    allocate(11'd99);
    release_at(32'd124);
    allocate(11'd40);
    release_at(32'd8);
    settle();
    // shrink the arena below live blocks
    program_arena(11'd64, 32'd0);
    release_at(32'd279);
    allocate(11'd10);
    settle();
    program_arena(11'd16, 32'hFFFF_FFF8);
    allocate(11'd0);
    settle();
    // oversize arena with a base that wraps payload addresses
    program_arena(11'd2047, 32'hFFFF_FFFF);
    release_at(32'hFFFF_FFFF + 32'd16 + 32'(HDR));
    allocate(11'd1024);
    allocate(11'd7);
    settle();

    for (int p = 0; p < 7; p++) begin
      base = (p == 0) ? 32'd0 : (p == 1) ? 32'hFFFF_FFFF : 32'($urandom);
      program_arena(phase_arena[p], base);
      churn(phase_items[p]);
      settle();
    end
    repeat (140) @(posedge clk);

    if (sb.outstanding() != 0)
      sb.flag_error($sformatf("%0d results never arrived", sb.outstanding()));
    $display("Covered %0d requests: %0d grants (%0d on reused blocks), %0d out of memory, %0d no fit",
             sb.requests, sb.grants, sb.reuses, sb.ooms, sb.nofits);
    $display("Frees: %0d, flagged invalid: %0d; output back-pressure holds: %0d; mismatches: %0d",
             sb.frees, sb.bad_frees, hold_count, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
